/* rtl/mpq_pkg.sv */
// Shared types and constants for the multi-policy ready queue.
// No dependencies; compiled first.
package mpq_pkg;

    localparam int ID_W     = 8;
    localparam int KEY_W    = 32;
    localparam int MODE_W   = 2;
    localparam int POLICY_W = 3;
    localparam int PRIO_W   = 8;
    localparam int BURST_W  = 16;
    localparam int REMAIN_W = 16;
    localparam int DUE_W    = 32;

    // APB register map
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_BIT = 2;

    typedef enum logic [REG_IDX_BIT-1:0] {
        REG_POLICY = 2'd0
    } reg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_PEEK   = 2'd2
    } mode_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_FCFS     = 3'd0,
        POL_RR       = 3'd1,
        POL_PRIORITY = 3'd2,
        POL_SJF      = 3'd3,
        POL_SRTN     = 3'd4,
        POL_EDF      = 3'd5
    } policy_t;

    // Per-cell control for one update step
    typedef struct packed {
        logic do_ins;   // insert that fits
        logic do_rem;   // remove request
        logic sorted;   // keyed policy in force
        logic ins_any;  // some occupied cell holds a larger key
        logic occ;      // this cell holds an entry
        logic tail;     // this cell is the first free slot
    } cell_ctl_t;

endpackage

/* rtl/mpq_cmd_if.sv */
// Command channel: valid/ready handshake with the queue request payload.
// Depends on mpq_pkg.
interface mpq_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [mpq_pkg::MODE_W-1:0]    mode;
    logic [mpq_pkg::ID_W-1:0]      ship_id;
    logic [mpq_pkg::PRIO_W-1:0]    prio_value;
    logic [mpq_pkg::BURST_W-1:0]   burst_len;
    logic [mpq_pkg::REMAIN_W-1:0]  remaining_len;
    logic [mpq_pkg::DUE_W-1:0]     due_time;

    modport source (
        output valid, mode, ship_id, prio_value, burst_len, remaining_len, due_time,
        input  ready
    );
    modport sink (
        input  valid, mode, ship_id, prio_value, burst_len, remaining_len, due_time,
        output ready
    );
endinterface

/* rtl/mpq_rsp_if.sv */
// Response channel: valid/ready handshake with the queue status payload.
// Depends on mpq_pkg; CNT_W follows the queue depth.
interface mpq_rsp_if #(
    parameter int CNT_W = 5
);
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic                      head_valid;
    logic [mpq_pkg::ID_W-1:0]  head_id;
    logic [CNT_W-1:0]          count;

    modport source (
        output valid, ok, head_valid, head_id, count,
        input  ready
    );
    modport sink (
        input  valid, ok, head_valid, head_id, count,
        output ready
    );
endinterface

/* rtl/mpq_cell.sv */
// One slot of the sorted shift-register queue: holds an id and a key,
// compares against the incoming item and takes data from a neighbor. Depends on mpq_pkg.
module mpq_cell (
    input  logic                        clk,
    input  mpq_pkg::cell_ctl_t          ctl,
    input  logic [mpq_pkg::ID_W-1:0]    new_id,
    input  logic [mpq_pkg::KEY_W-1:0]   new_key,
    input  logic [mpq_pkg::ID_W-1:0]    left_id,
    input  logic [mpq_pkg::KEY_W-1:0]   left_key,
    input  logic [mpq_pkg::ID_W-1:0]    right_id,
    input  logic [mpq_pkg::KEY_W-1:0]   right_key,
    input  logic                        ins_seen_in,
    input  logic                        rem_seen_in,
    output logic                        ins_seen_out,
    output logic                        rem_seen_out,
    output logic [mpq_pkg::ID_W-1:0]    id_q,
    output logic [mpq_pkg::KEY_W-1:0]   key_q,
    output logic [mpq_pkg::ID_W-1:0]    id_next_q
);

    logic [mpq_pkg::ID_W-1:0]  id_reg;
    logic [mpq_pkg::ID_W-1:0]  id_next;
    logic [mpq_pkg::KEY_W-1:0] key_reg;
    logic [mpq_pkg::KEY_W-1:0] key_next;
    logic                      ins_hit;
    logic                      rem_hit;
    logic                      load_new;

    // Compare the incoming item against the stored entry
    assign ins_hit = ctl.occ & ctl.sorted & (new_key < key_reg);
    assign rem_hit = ctl.occ & (new_id == id_reg);

    // Pass the first-hit marks down the chain
    assign ins_seen_out = ins_seen_in | ins_hit;
    assign rem_seen_out = rem_seen_in | rem_hit;

    // Load here at the first larger key, or at the tail when none is larger
    assign load_new = (ins_hit & ~ins_seen_in) | (~ctl.ins_any & ctl.tail);

    // Select new contents: load, shift toward tail, shift toward head, or hold
    always_comb
    begin
        id_next  = id_reg;
        key_next = key_reg;
        if (ctl.do_ins)
        begin
            if (load_new)
            begin
                id_next  = new_id;
                key_next = new_key;
            end
            else if (ins_seen_in)
            begin
                id_next  = left_id;
                key_next = left_key;
            end
        end
        else if (ctl.do_rem)
        begin
            if (rem_seen_in | rem_hit)
            begin
                id_next  = right_id;
                key_next = right_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
    end

    assign id_q      = id_reg;
    assign key_q     = key_reg;
    assign id_next_q = id_next;

endmodule

/* rtl/multi_policy_ready_queue_unit.sv */
// Top level of the multi-policy ready queue: policy register, chain of slot cells,
// entry count and response register. Depends on mpq_pkg, mpq_cmd_if, mpq_rsp_if, mpq_cell.

// The queue keeps up to QUEUE_DEPTH entries in a row of slot cells, head in cell 0,
// and completes one insert, remove or peek per clock: the command is applied to
// every cell in the cycle it transfers, and its status (ok, head, count after the
// step) appears in a response register on the next cycle. A new command is taken
// whenever that register is empty or being drained, so the sustained rate is one
// command per cycle; the path that sets the clock is the key compare in each cell
// plus the first-match chain that runs through all cells. FCFS and RR append at the
// tail; priority, SJF, SRTN and EDF insert ahead of the first entry with a strictly
// larger key. Write the policy register (APB address 0) only while the queue is
// empty; entries already stored keep their keys and are not re-sorted.
module multi_policy_ready_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mpq_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mpq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mpq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    mpq_cmd_if.sink                           cmd,
    mpq_rsp_if.source                         rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [mpq_pkg::POLICY_W-1:0] policy_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         rsp_valid_reg;
    logic                         ok_reg;
    logic                         ok_next;
    logic                         head_valid_reg;
    logic [mpq_pkg::ID_W-1:0]     head_id_reg;
    logic [mpq_pkg::ID_W-1:0]     head_id_next;
    logic [CNT_W-1:0]             rsp_count_reg;

    logic                         reg_sel;
    logic                         xfer;
    logic                         sorted;
    logic                         full;
    logic                         do_ins;
    logic                         do_rem;
    logic [mpq_pkg::KEY_W-1:0]    new_key;
    logic                         ins_any;
    logic                         rem_any;

    logic [mpq_pkg::ID_W-1:0]     cell_id  [QUEUE_DEPTH];
    logic [mpq_pkg::KEY_W-1:0]    cell_key [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]         ins_seen;
    logic [QUEUE_DEPTH:0]         rem_seen;
    mpq_pkg::cell_ctl_t           cell_ctl [QUEUE_DEPTH];

    // APB register access
    assign pready  = 1'b1;
    assign reg_sel = (paddr[mpq_pkg::APB_ADDR_W-1:mpq_pkg::REG_IDX_BIT]
                      == 1'(mpq_pkg::REG_POLICY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            policy_reg <= mpq_pkg::POL_FCFS;
        else if (psel && penable && pwrite && pready && reg_sel)
            policy_reg <= pwdata[mpq_pkg::POLICY_W-1:0];
    end

    assign prdata = reg_sel ? mpq_pkg::APB_DATA_W'(policy_reg) : '0;

    // Command decode and key selection
    assign cmd.ready = ~rsp_valid_reg | rsp.ready;
    assign xfer      = cmd.valid & cmd.ready;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_ins    = xfer & (cmd.mode == mpq_pkg::MODE_INSERT) & ~full;
    assign do_rem    = xfer & (cmd.mode == mpq_pkg::MODE_REMOVE);

    always_comb
    begin
        sorted  = 1'b1;
        new_key = '0;
        case (policy_reg)
            mpq_pkg::POL_PRIORITY: new_key = mpq_pkg::KEY_W'(cmd.prio_value);
            mpq_pkg::POL_SJF:      new_key = mpq_pkg::KEY_W'(cmd.burst_len);
            mpq_pkg::POL_SRTN:     new_key = mpq_pkg::KEY_W'(cmd.remaining_len);
            mpq_pkg::POL_EDF:      new_key = mpq_pkg::KEY_W'(cmd.due_time);
            default:               sorted  = 1'b0;
        endcase
    end

    assign ins_seen[0] = 1'b0;
    assign rem_seen[0] = 1'b0;
    assign ins_any     = ins_seen[QUEUE_DEPTH];
    assign rem_any     = rem_seen[QUEUE_DEPTH];

    // Chain of slot cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        localparam int LEFT  = (i == 0) ? 0 : i - 1;
        localparam int RIGHT = (i == QUEUE_DEPTH - 1) ? i : i + 1;

        always_comb
        begin
            cell_ctl[i].do_ins  = do_ins;
            cell_ctl[i].do_rem  = do_rem;
            cell_ctl[i].sorted  = sorted;
            cell_ctl[i].ins_any = ins_any;
            cell_ctl[i].occ     = (CNT_W'(i) < count_reg);
            cell_ctl[i].tail    = (CNT_W'(i) == count_reg);
        end

        if (i == 0)
        begin : g_head
            mpq_cell u_cell (
                .clk          (clk),
                .ctl          (cell_ctl[i]),
                .new_id       (cmd.ship_id),
                .new_key      (new_key),
                .left_id      (cell_id[LEFT]),
                .left_key     (cell_key[LEFT]),
                .right_id     (cell_id[RIGHT]),
                .right_key    (cell_key[RIGHT]),
                .ins_seen_in  (ins_seen[i]),
                .rem_seen_in  (rem_seen[i]),
                .ins_seen_out (ins_seen[i+1]),
                .rem_seen_out (rem_seen[i+1]),
                .id_q         (cell_id[i]),
                .key_q        (cell_key[i]),
                .id_next_q    (head_id_next)
            );
        end
        else
        begin : g_body
            mpq_cell u_cell (
                .clk          (clk),
                .ctl          (cell_ctl[i]),
                .new_id       (cmd.ship_id),
                .new_key      (new_key),
                .left_id      (cell_id[LEFT]),
                .left_key     (cell_key[LEFT]),
                .right_id     (cell_id[RIGHT]),
                .right_key    (cell_key[RIGHT]),
                .ins_seen_in  (ins_seen[i]),
                .rem_seen_in  (rem_seen[i]),
                .ins_seen_out (ins_seen[i+1]),
                .rem_seen_out (rem_seen[i+1]),
                .id_q         (cell_id[i]),
                .key_q        (cell_key[i]),
                .id_next_q    ()
            );
        end
    end

    // Step status and next count
    always_comb
    begin
        count_next = count_reg;
        ok_next    = 1'b0;
        case (cmd.mode)
            mpq_pkg::MODE_INSERT:
            begin
                ok_next = ~full;
                if (~full)
                    count_next = count_reg + CNT_W'(1);
            end
            mpq_pkg::MODE_REMOVE:
            begin
                ok_next = rem_any;
                if (rem_any)
                    count_next = count_reg - CNT_W'(1);
            end
            mpq_pkg::MODE_PEEK:
                ok_next = (count_reg != '0);
            default:
                ok_next = 1'b0;
        endcase
    end

    // Advance the entry count on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (xfer)
            count_reg <= count_next;
    end

    // Hold the response until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (xfer)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            ok_reg         <= ok_next;
            head_valid_reg <= (count_next != '0);
            head_id_reg    <= (count_next != '0) ? head_id_next : '0;
            rsp_count_reg  <= count_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = ok_reg;
    assign rsp.head_valid = head_valid_reg;
    assign rsp.head_id    = head_id_reg;
    assign rsp.count      = rsp_count_reg;

endmodule
